### rtl/ddnpm_pkg.sv
// Shared constants, codes and control types for the dual deque node pool manager.
package ddnpm_pkg;

    // Default pool size and fixed field widths
    localparam int POOL_NODES_DEF = 1024;
    localparam int KIND_W         = 2;
    localparam int STAT_W         = 2;
    localparam int CFG_W          = 11;

    // Reset value of the nodes_in_use register
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_TAKE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RETURN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REBUILD = 2'd2;
    localparam logic [KIND_W-1:0] KIND_NOP     = 2'd3;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture request, issue link read
        logic exec;   // main work cycle
        logic link2;  // second link write of a return
        logic sweep;  // one rebuild node
        logic done;   // result goes out next cycle
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic ret_link2;   // return into a non-empty list needs a second write
        logic sweep_go;    // rebuild with at least one node
        logic sweep_last;  // current rebuild node is the last one
    } t_stat;

endpackage

### rtl/dual_deque_node_pool_manager.sv
// Top level of the dual deque node pool manager: sequencer plus datapath.
//
// A request is taken when start is high and busy is low; its single result
// appears on o_status, o_taken_node and o_list_count for exactly one cycle,
// marked by o_done, and must be captured then. A take, a no-op kind, or a
// return that is rejected or lands in an empty list needs only the exec
// state; a return into a non-empty list adds the link2 state, because each
// link memory has one write port and that return rewrites one memory at two
// addresses. A non-empty rebuild adds the sweep state, writing the links of
// min(nodes_in_use, POOL_NODES) nodes, one node's links per cycle. The result
// strobe comes in the cycle after the last work cycle, while the next request
// may already be taken. nodes_in_use may be written only while the block is idle.
module dual_deque_node_pool_manager #(
    parameter  int POOL_NODES = ddnpm_pkg::POOL_NODES_DEF,
    localparam int NODE_W     = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1,
    localparam int CNT_W      = $clog2(POOL_NODES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [ddnpm_pkg::KIND_W-1:0]  i_kind,
    input  logic                          i_use_free_list,
    input  logic                          i_at_front,
    input  logic [NODE_W-1:0]             i_node_number,
    input  logic                          i_cfg_we,
    input  logic [ddnpm_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic                          o_done,
    output logic [ddnpm_pkg::STAT_W-1:0]  o_status,
    output logic [NODE_W-1:0]             o_taken_node,
    output logic [CNT_W-1:0]              o_list_count
);

    ddnpm_pkg::t_cmd  cmd;
    ddnpm_pkg::t_stat stat;

    // Sequencer
    ddnpm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    // Lists, link memories and results
    ddnpm_dp #(
        .POOL_NODES (POOL_NODES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_kind          (i_kind),
        .i_use_free_list (i_use_free_list),
        .i_at_front      (i_at_front),
        .i_node_number   (i_node_number),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_taken_node    (o_taken_node),
        .o_list_count    (o_list_count)
    );

endmodule

### rtl/ddnpm_ctrl.sv
// Request sequencer for the dual deque node pool manager.
module ddnpm_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  ddnpm_pkg::t_stat  i_stat,
    output ddnpm_pkg::t_cmd   o_cmd,
    output logic              busy
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_LINK2 = 4'b0100,
        S_SWEEP = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.ret_link2) begin
                    n_state = S_LINK2;
                end else if (i_stat.sweep_go) begin
                    n_state = S_SWEEP;
                end else begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_LINK2: begin
                o_cmd.link2 = 1'b1;
                o_cmd.done  = 1'b1;
                n_state     = S_IDLE;
            end
            S_SWEEP: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

### rtl/ddnpm_dp.sv
// Datapath: list registers, link memories, rebuild counter and result registers.
module ddnpm_dp #(
    parameter  int POOL_NODES = ddnpm_pkg::POOL_NODES_DEF,
    localparam int NODE_W     = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1,
    localparam int CNT_W      = $clog2(POOL_NODES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ddnpm_pkg::t_cmd               i_cmd,
    output ddnpm_pkg::t_stat              o_stat,
    input  logic [ddnpm_pkg::KIND_W-1:0]  i_kind,
    input  logic                          i_use_free_list,
    input  logic                          i_at_front,
    input  logic [NODE_W-1:0]             i_node_number,
    input  logic                          i_cfg_we,
    input  logic [ddnpm_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic                          o_done,
    output logic [ddnpm_pkg::STAT_W-1:0]  o_status,
    output logic [NODE_W-1:0]             o_taken_node,
    output logic [CNT_W-1:0]              o_list_count
);

    // Link memories, indexed by node number
    logic [NODE_W-1:0] r_next_link [POOL_NODES];
    logic [NODE_W-1:0] r_prev_link [POOL_NODES];
    logic [NODE_W-1:0] r_nx_rd;
    logic [NODE_W-1:0] r_pv_rd;

    // List registers
    logic [NODE_W-1:0] r_free_head, r_free_tail, r_data_head, r_data_tail;
    logic [CNT_W-1:0]  r_free_count, r_data_count;

    // Captured request
    logic [ddnpm_pkg::KIND_W-1:0] r_kind;
    logic                         r_use_free;
    logic                         r_front;
    logic [NODE_W-1:0]            r_node;

    // Configuration and rebuild walk
    logic [ddnpm_pkg::CFG_W-1:0] r_nodes_in_use;
    logic [NODE_W-1:0]           r_idx;
    logic [CNT_W-1:0]            r_sweep_n;

    // Result registers
    logic                         r_done;
    logic [ddnpm_pkg::STAT_W-1:0] r_status;
    logic [NODE_W-1:0]            r_taken;
    logic [CNT_W-1:0]             r_count;

    // Combinational
    logic [NODE_W-1:0]            rd_addr;
    logic [NODE_W-1:0]            cur_head, cur_tail;
    logic [CNT_W-1:0]             cur_count;
    logic                         list_empty, ret_bad, sweep_last;
    logic [CNT_W-1:0]             sweep_n;
    logic                         upd;
    logic [NODE_W-1:0]            new_head, new_tail;
    logic [CNT_W-1:0]             new_count;
    logic [ddnpm_pkg::STAT_W-1:0] res_status;
    logic [NODE_W-1:0]            res_taken;
    logic                         nx_we, pv_we;
    logic [NODE_W-1:0]            nx_addr, pv_addr, nx_wdata, pv_wdata;

    // Read address from the incoming request: end of the addressed list
    always_comb begin
        if (i_use_free_list) begin
            rd_addr = i_at_front ? r_free_head : r_free_tail;
        end else begin
            rd_addr = i_at_front ? r_data_head : r_data_tail;
        end
    end

    // Addressed list
    assign cur_head   = r_use_free ? r_free_head  : r_data_head;
    assign cur_tail   = r_use_free ? r_free_tail  : r_data_tail;
    assign cur_count  = r_use_free ? r_free_count : r_data_count;
    assign list_empty = (cur_count == '0);
    assign ret_bad    = (32'(r_node) >= 32'(POOL_NODES)) ||
                        (32'(cur_count) >= 32'(POOL_NODES));

    // Rebuild length, saturated at the pool size
    always_comb begin
        if (32'(r_nodes_in_use) > 32'(POOL_NODES)) begin
            sweep_n = CNT_W'(POOL_NODES);
        end else begin
            sweep_n = CNT_W'(r_nodes_in_use);
        end
    end
    assign sweep_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_sweep_n);

    // Status toward the controller
    assign o_stat.ret_link2  = (r_kind == ddnpm_pkg::KIND_RETURN) && !ret_bad && !list_empty;
    assign o_stat.sweep_go   = (r_kind == ddnpm_pkg::KIND_REBUILD) && (sweep_n != '0);
    assign o_stat.sweep_last = sweep_last;

    // Operation decode: list update, result and link writes
    always_comb begin
        upd        = 1'b0;
        new_head   = cur_head;
        new_tail   = cur_tail;
        new_count  = cur_count;
        res_status = ddnpm_pkg::ST_OK;
        res_taken  = '0;
        nx_we      = 1'b0;
        pv_we      = 1'b0;
        nx_addr    = r_node;
        pv_addr    = r_node;
        nx_wdata   = '0;
        pv_wdata   = '0;
        if (i_cmd.exec) begin
            case (r_kind)
                ddnpm_pkg::KIND_TAKE: begin
                    if (list_empty) begin
                        res_status = ddnpm_pkg::ST_EMPTY;
                    end else begin
                        upd       = 1'b1;
                        new_count = cur_count - CNT_W'(1);
                        if (cur_count == CNT_W'(1)) begin
                            res_taken = cur_head;
                            new_head  = '0;
                            new_tail  = '0;
                        end else if (r_front) begin
                            res_taken = cur_head;
                            new_head  = r_nx_rd;
                        end else begin
                            res_taken = cur_tail;
                            new_tail  = r_pv_rd;
                        end
                    end
                end
                ddnpm_pkg::KIND_RETURN: begin
                    if (ret_bad) begin
                        res_status = ddnpm_pkg::ST_RANGE;
                    end else begin
                        upd       = 1'b1;
                        new_count = cur_count + CNT_W'(1);
                        nx_we     = 1'b1;
                        pv_we     = 1'b1;
                        if (list_empty) begin
                            // first node: own links cleared
                            new_head = r_node;
                            new_tail = r_node;
                        end else if (r_front) begin
                            nx_wdata = cur_head;
                            pv_addr  = cur_head;
                            pv_wdata = r_node;
                            new_head = r_node;
                        end else begin
                            nx_addr  = cur_tail;
                            nx_wdata = r_node;
                            pv_wdata = cur_tail;
                            new_tail = r_node;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        // second write clears the new end's outward link
        if (i_cmd.link2) begin
            if (r_front) begin
                pv_we = 1'b1;
            end else begin
                nx_we = 1'b1;
            end
        end
        // rebuild: node idx links to idx-1 (next) and idx+1 (prev)
        if (i_cmd.sweep) begin
            nx_we    = 1'b1;
            pv_we    = 1'b1;
            nx_addr  = r_idx;
            pv_addr  = r_idx;
            nx_wdata = (r_idx == '0) ? '0 : r_idx - NODE_W'(1);
            pv_wdata = sweep_last ? '0 : r_idx + NODE_W'(1);
        end
    end

    // Next link memory
    always_ff @(posedge i_clk) begin
        if (nx_we) begin
            r_next_link[nx_addr] <= nx_wdata;
        end
        if (i_cmd.load) begin
            r_nx_rd <= r_next_link[rd_addr];
        end
    end

    // Previous link memory
    always_ff @(posedge i_clk) begin
        if (pv_we) begin
            r_prev_link[pv_addr] <= pv_wdata;
        end
        if (i_cmd.load) begin
            r_pv_rd <= r_prev_link[rd_addr];
        end
    end

    // Request capture, rebuild walk and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= i_kind;
            r_use_free <= i_use_free_list;
            r_front    <= i_at_front;
            r_node     <= i_node_number;
        end
        if (i_cmd.exec) begin
            r_status  <= res_status;
            r_taken   <= res_taken;
            r_sweep_n <= sweep_n;
            r_idx     <= '0;
            if (r_kind == ddnpm_pkg::KIND_REBUILD) begin
                r_count <= sweep_n;
            end else begin
                r_count <= new_count;
            end
        end else if (i_cmd.sweep) begin
            r_idx <= r_idx + NODE_W'(1);
        end
    end

    // List registers, configuration and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head    <= '0;
            r_free_tail    <= '0;
            r_free_count   <= '0;
            r_data_head    <= '0;
            r_data_tail    <= '0;
            r_data_count   <= '0;
            r_nodes_in_use <= ddnpm_pkg::CFG_RESET;
            r_done         <= 1'b0;
        end else begin
            r_done <= i_cmd.done;
            if (i_cfg_we) begin
                r_nodes_in_use <= i_cfg_wdata;
            end
            if (i_cmd.exec && (r_kind == ddnpm_pkg::KIND_REBUILD)) begin
                r_free_head  <= (sweep_n == '0) ? '0 : NODE_W'(sweep_n - CNT_W'(1));
                r_free_tail  <= '0;
                r_free_count <= sweep_n;
                r_data_head  <= '0;
                r_data_tail  <= '0;
                r_data_count <= '0;
            end else if (upd) begin
                if (r_use_free) begin
                    r_free_head  <= new_head;
                    r_free_tail  <= new_tail;
                    r_free_count <= new_count;
                end else begin
                    r_data_head  <= new_head;
                    r_data_tail  <= new_tail;
                    r_data_count <= new_count;
                end
            end
        end
    end

    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_taken_node = r_taken;
    assign o_list_count = r_count;

endmodule

### rtl/ddnpm_chk.sv
// Port-level checker for the dual deque node pool manager, bound to the top level.
module ddnpm_chk #(
    parameter  int POOL_NODES = ddnpm_pkg::POOL_NODES_DEF,
    localparam int NODE_W     = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1,
    localparam int CNT_W      = $clog2(POOL_NODES + 1)
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [ddnpm_pkg::KIND_W-1:0]  i_kind,
    input logic                          i_use_free_list,
    input logic                          i_at_front,
    input logic [NODE_W-1:0]             i_node_number,
    input logic                          i_cfg_we,
    input logic [ddnpm_pkg::CFG_W-1:0]   i_cfg_wdata,
    input logic                          o_done,
    input logic [ddnpm_pkg::STAT_W-1:0]  o_status,
    input logic [NODE_W-1:0]             o_taken_node,
    input logic [CNT_W-1:0]              o_list_count
);

    // An accepted request makes the block busy in the following cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted request");

    // No result strobe in two consecutive cycles
    a_done_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe on two consecutive cycles");

    // No result strobe right after a request is taken
    a_no_done_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_done)
        else $error("result strobe in the cycle after acceptance");

    // Empty take reports no node and an empty list
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ddnpm_pkg::ST_EMPTY)) |->
            ((o_taken_node == '0) && (o_list_count == '0)))
        else $error("empty-list result carries a node or a count");

    // Rejected return reports no node
    a_range_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ddnpm_pkg::ST_RANGE)) |-> (o_taken_node == '0))
        else $error("rejected request carries a node");

endmodule

bind dual_deque_node_pool_manager ddnpm_chk #(.POOL_NODES(POOL_NODES)) u_ddnpm_chk (.*);

### bench/tb_dual_deque_node_pool_manager.sv
// Testbench for the dual deque node pool manager: directed and random requests checked against a local pool model.
module tb_dual_deque_node_pool_manager;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POOL       = ddnpm_pkg::POOL_NODES_DEF;
    localparam int NODE_W     = $clog2(POOL);
    localparam int CNT_W      = $clog2(POOL + 1);
    localparam int CYCLE_MAX  = 8000000;
    localparam bit DATA_LIST  = 1'b0;
    localparam bit FREE_LIST  = 1'b1;
    localparam bit AT_HEAD    = 1'b1;
    localparam bit AT_TAIL    = 1'b0;

    typedef struct packed {
        logic [ddnpm_pkg::STAT_W-1:0] status;
        logic [NODE_W-1:0]            taken;
        logic [CNT_W-1:0]             count;
    } t_pool_result;

    typedef struct {
        logic [NODE_W-1:0] head;
        logic [NODE_W-1:0] tail;
        logic [CNT_W-1:0]  count;
    } t_deque_regs;

    // DUT ports, every input driven from time zero
    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          start           = 1'b0;
    logic                          busy;
    logic [ddnpm_pkg::KIND_W-1:0]  i_kind          = ddnpm_pkg::KIND_NOP;
    logic                          i_use_free_list = 1'b0;
    logic                          i_at_front      = 1'b0;
    logic [NODE_W-1:0]             i_node_number   = '0;
    logic                          i_cfg_we        = 1'b0;
    logic [ddnpm_pkg::CFG_W-1:0]   i_cfg_wdata     = '0;
    logic                          o_done;
    logic [ddnpm_pkg::STAT_W-1:0]  o_status;
    logic [NODE_W-1:0]             o_taken_node;
    logic [CNT_W-1:0]              o_list_count;

    // Pool model state: shared link memories, both deques, rebuild size
    logic [NODE_W-1:0]             fwd_link [POOL];
    logic [NODE_W-1:0]             back_link [POOL];
    t_deque_regs                   deque [2];
    logic [ddnpm_pkg::CFG_W-1:0]   rebuild_size;

    t_pool_result                  pending_results [$];
    t_pool_result                  last_predicted;
    logic [NODE_W-1:0]             held_nodes [$];
    int                            mismatch_count = 0;
    int                            cycle_count    = 0;

    dual_deque_node_pool_manager dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_use_free_list (i_use_free_list),
        .i_at_front      (i_at_front),
        .i_node_number   (i_node_number),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_taken_node    (o_taken_node),
        .o_list_count    (o_list_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Link a node in at one end of a deque
    function automatic void deque_push(input bit sel, input logic [NODE_W-1:0] n,
                                       input bit front);
        if (deque[sel].count == 0) begin
            fwd_link[n]      = '0;
            back_link[n]     = '0;
            deque[sel].head  = n;
            deque[sel].tail  = n;
            deque[sel].count = CNT_W'(1);
            return;
        end
        if (front) begin
            fwd_link[n]                = deque[sel].head;
            back_link[deque[sel].head] = n;
            back_link[n]               = '0;
            deque[sel].head            = n;
        end else begin
            fwd_link[deque[sel].tail] = n;
            back_link[n]              = deque[sel].tail;
            fwd_link[n]               = '0;
            deque[sel].tail           = n;
        end
        deque[sel].count = deque[sel].count + CNT_W'(1);
    endfunction

    // Unlink the node at one end of a non-empty deque
    function automatic logic [NODE_W-1:0] deque_pop(input bit sel, input bit front);
        logic [NODE_W-1:0] n;
        if (deque[sel].count == 1) begin
            n                = deque[sel].head;
            deque[sel].head  = '0;
            deque[sel].tail  = '0;
            deque[sel].count = '0;
            return n;
        end
        if (front) begin
            n               = deque[sel].head;
            deque[sel].head = fwd_link[n];
        end else begin
            n               = deque[sel].tail;
            deque[sel].tail = back_link[n];
        end
        deque[sel].count = deque[sel].count - CNT_W'(1);
        return n;
    endfunction

    // Apply one request to the pool model and return its result
    function automatic t_pool_result pool_apply(input logic [ddnpm_pkg::KIND_W-1:0] kind,
                                                input bit on_free, input bit front,
                                                input logic [NODE_W-1:0] node);
        t_pool_result r;
        bit           sel;
        int           fill;
        r   = '0;
        sel = on_free;
        case (kind)
            ddnpm_pkg::KIND_TAKE: begin
                if (deque[sel].count == 0)
                    r.status = ddnpm_pkg::ST_EMPTY;
                else
                    r.taken = deque_pop(sel, front);
            end
            ddnpm_pkg::KIND_RETURN: begin
                if (deque[sel].count >= POOL)
                    r.status = ddnpm_pkg::ST_RANGE;
                else
                    deque_push(sel, node, front);
            end
            ddnpm_pkg::KIND_REBUILD: begin
                fill = (rebuild_size > POOL) ? POOL : int'(rebuild_size);
                foreach (deque[i]) begin
                    deque[i].head  = '0;
                    deque[i].tail  = '0;
                    deque[i].count = '0;
                end
                for (int i = 0; i < fill; i++)
                    deque_push(FREE_LIST, NODE_W'(i), AT_HEAD);
                sel = FREE_LIST;
            end
            default: ;
        endcase
        r.count = deque[sel].count;
        return r;
    endfunction

    // Present one request and hold it until the block takes it
    task automatic send_request(input logic [ddnpm_pkg::KIND_W-1:0] kind, input bit on_free,
                                input bit front, input logic [NODE_W-1:0] node);
        start           <= 1'b1;
        i_kind          <= kind;
        i_use_free_list <= on_free;
        i_at_front      <= front;
        i_node_number   <= node;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        last_predicted = pool_apply(kind, on_free, front, node);
        pending_results.push_back(last_predicted);
    endtask

    task automatic pause_requests(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Wait for every outstanding result and let the block settle
    task automatic drain_requests();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_nodes_in_use(input logic [ddnpm_pkg::CFG_W-1:0] value);
        drain_requests();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        rebuild_size = value;
    endtask

    // Fresh from reset: both lists empty, no link memory touched
    task automatic test_empty_lists();
        send_request(ddnpm_pkg::KIND_TAKE, FREE_LIST, AT_HEAD, '0);
        send_request(ddnpm_pkg::KIND_TAKE, FREE_LIST, AT_TAIL, '0);
        send_request(ddnpm_pkg::KIND_TAKE, DATA_LIST, AT_HEAD, '1);
        send_request(ddnpm_pkg::KIND_TAKE, DATA_LIST, AT_TAIL, '1);
        send_request(ddnpm_pkg::KIND_NOP, FREE_LIST, AT_HEAD, '1);
        send_request(ddnpm_pkg::KIND_NOP, DATA_LIST, AT_TAIL, '0);
    endtask

    // Full rebuild at the reset size, full list, both ends, last node
    task automatic test_full_pool();
        send_request(ddnpm_pkg::KIND_REBUILD, DATA_LIST, AT_HEAD, '0);
        send_request(ddnpm_pkg::KIND_RETURN, FREE_LIST, AT_TAIL, NODE_W'(5));
        send_request(ddnpm_pkg::KIND_TAKE, FREE_LIST, AT_HEAD, '0);
        send_request(ddnpm_pkg::KIND_TAKE, FREE_LIST, AT_TAIL, '0);
        send_request(ddnpm_pkg::KIND_RETURN, DATA_LIST, AT_HEAD, '1);
        send_request(ddnpm_pkg::KIND_RETURN, DATA_LIST, AT_TAIL, '0);
        send_request(ddnpm_pkg::KIND_TAKE, DATA_LIST, AT_TAIL, '0);
        send_request(ddnpm_pkg::KIND_TAKE, DATA_LIST, AT_TAIL, '0);
        send_request(ddnpm_pkg::KIND_TAKE, DATA_LIST, AT_HEAD, '0);
    endtask

    // Rebuild with zero nodes, a saturating size, and a single node
    task automatic test_rebuild_extremes();
        set_nodes_in_use(11'd0);
        send_request(ddnpm_pkg::KIND_REBUILD, FREE_LIST, AT_TAIL, '1);
        send_request(ddnpm_pkg::KIND_TAKE, FREE_LIST, AT_HEAD, '0);
        set_nodes_in_use(11'd2047);
        send_request(ddnpm_pkg::KIND_REBUILD, DATA_LIST, AT_TAIL, NODE_W'(10'h2AA));
        set_nodes_in_use(11'd1);
        send_request(ddnpm_pkg::KIND_REBUILD, FREE_LIST, AT_HEAD, NODE_W'(10'h155));
        send_request(ddnpm_pkg::KIND_TAKE, FREE_LIST, AT_TAIL, '0);
        send_request(ddnpm_pkg::KIND_RETURN, FREE_LIST, AT_HEAD, NODE_W'(512));
        send_request(ddnpm_pkg::KIND_RETURN, FREE_LIST, AT_TAIL, NODE_W'(511));
    endtask

    // Pool traffic: mostly take-then-return of held nodes, plus noise
    task automatic test_random_traffic(input int items,
                                       input logic [ddnpm_pkg::CFG_W-1:0] size,
                                       input bit with_gaps);
        int                           pick;
        int                           slot;
        bit                           on_free;
        bit                           front;
        logic [NODE_W-1:0]            node;
        logic [ddnpm_pkg::KIND_W-1:0] kind;
        set_nodes_in_use(size);
        send_request(ddnpm_pkg::KIND_REBUILD, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), NODE_W'($urandom_range(0, POOL - 1)));
        held_nodes.delete();
        repeat (items) begin
            pick    = int'($urandom_range(0, 99));
            on_free = 1'($urandom_range(0, 1));
            front   = 1'($urandom_range(0, 1));
            node    = NODE_W'($urandom_range(0, POOL - 1));
            if (pick < 30) begin
                kind    = ddnpm_pkg::KIND_TAKE;
                on_free = FREE_LIST;
            end else if (pick < 48) begin
                kind    = ddnpm_pkg::KIND_TAKE;
                on_free = DATA_LIST;
            end else if (pick < 83) begin
                kind = ddnpm_pkg::KIND_RETURN;
                if (held_nodes.size() != 0 && $urandom_range(0, 9) != 0) begin
                    slot = int'($urandom_range(0, held_nodes.size() - 1));
                    node = held_nodes[slot];
                    held_nodes.delete(slot);
                    on_free = ($urandom_range(0, 9) < 4);
                end
            end else if (pick < 92) begin
                kind = ddnpm_pkg::KIND_RETURN;
            end else if (pick < 96) begin
                kind = ddnpm_pkg::KIND_NOP;
            end else if (pick < 98) begin
                kind = ddnpm_pkg::KIND_TAKE;
            end else begin
                kind = ddnpm_pkg::KIND_REBUILD;
                held_nodes.delete();
            end
            send_request(kind, on_free, front, node);
            if (kind == ddnpm_pkg::KIND_TAKE && last_predicted.status == ddnpm_pkg::ST_OK)
                held_nodes.push_back(last_predicted.taken);
            if (with_gaps && $urandom_range(0, 3) == 0)
                pause_requests($urandom_range(1, 6));
        end
    endtask

    // Result checker: every strobed result against the oldest prediction
    always @(posedge i_clk) begin
        t_pool_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d taken_node %0d list_count %0d",
                       o_status, o_taken_node, o_list_count);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_taken_node !== want.taken) begin
                    $error("taken_node: expected %0d, got %0d", want.taken, o_taken_node);
                    mismatch_count++;
                end
                if (o_list_count !== want.count) begin
                    $error("list_count: expected %0d, got %0d", want.count, o_list_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_MAX) begin
            $display("dual_deque_node_pool_manager test failed");
            $finish;
        end
    end

    initial begin
        foreach (fwd_link[i]) begin
            fwd_link[i]  = '0;
            back_link[i] = '0;
        end
        foreach (deque[i]) begin
            deque[i].head  = '0;
            deque[i].tail  = '0;
            deque[i].count = '0;
        end
        rebuild_size = ddnpm_pkg::CFG_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_lists();
        test_full_pool();
        test_rebuild_extremes();
        test_random_traffic(260, 11'd1024, 1'b1);
        test_random_traffic(180, 11'd1, 1'b1);
        test_random_traffic(220, 11'd2047, 1'b1);
        test_random_traffic(280, ddnpm_pkg::CFG_W'($urandom_range(2, 40)), 1'b1);
        test_random_traffic(120, 11'd0, 1'b1);
        test_random_traffic(250, ddnpm_pkg::CFG_W'($urandom_range(41, 1023)), 1'b1);
        test_random_traffic(240, 11'd16, 1'b0);

        drain_requests();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("dual_deque_node_pool_manager test passed");
        end else begin
            $display("dual_deque_node_pool_manager test failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/ddnpm_pkg.sv
rtl/ddnpm_ctrl.sv
rtl/ddnpm_dp.sv
rtl/dual_deque_node_pool_manager.sv
rtl/ddnpm_chk.sv
bench/tb_dual_deque_node_pool_manager.sv
